@@ rtl/box_header_scanner_unit_assert.svh @@
// Assertion macros for the box header scanner.
// BHS_ASSERT checks a property while out of reset; BHS_ASSERT_RST also
// checks during reset.
`ifndef BOX_HEADER_SCANNER_UNIT_ASSERT_SVH
`define BOX_HEADER_SCANNER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BHS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("box header scanner assertion failed");
`define BHS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("box header scanner reset assertion failed");
`else
`define BHS_ASSERT(lbl, prop)
`define BHS_ASSERT_RST(lbl, prop)
`endif
`endif

@@ rtl/bhs_pkg.sv @@
`default_nettype none
package bhs_pkg;

  localparam logic [4:0] HDR_SHORT = 5'd8;
  localparam logic [4:0] HDR_LONG  = 5'd16;

  localparam logic [1:0] CFG_RANGE_START  = 2'd0;
  localparam logic [1:0] CFG_RANGE_END    = 2'd1;
  localparam logic [1:0] CFG_TARGET_TYPE  = 2'd2;
  localparam logic [1:0] CFG_ALLOW_BEYOND = 2'd3;

  typedef enum logic [1:0] {
    OUTC_NONE     = 2'd0,
    OUTC_IN_RANGE = 2'd1,
    OUTC_BEYOND   = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [31:0] target_type;
    logic        allow_beyond;
  } cfg_t;

  typedef struct packed {
    logic [31:0] byte_pos;
    logic [31:0] box_start;
    logic [4:0]  hdr_cnt;
    logic [31:0] size_word;
    logic [31:0] type_word;
    logic [63:0] large_size;
    logic [63:0] skip_rem;
    logic        scan_done;
  } scan_state_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [31:0] header_offset;
    logic [31:0] payload_offset;
    logic [63:0] payload_size;
    logic [63:0] total_size;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/bhs_step.sv @@
`default_nettype none
// Per-byte scan step: next scan state and the optional result for one byte.
module bhs_step import bhs_pkg::*; (
  input  var scan_state_t cur,
  input  var cfg_t        cfg,
  input  wire [7:0]       data_byte,
  input  wire             last_byte,
  output scan_state_t     nxt,
  output logic            emit,
  output result_t         res
);

  logic        first;
  logic [31:0] bs;
  logic [4:0]  hc0;
  logic [4:0]  hc1;
  logic [63:0] skip0;
  logic [63:0] skip_dec;
  logic        done0;
  logic        fit8;
  logic        fit16;
  logic        fit24;
  logic [31:0] sw_sh;
  logic [31:0] tw_sh;
  logic [63:0] ls_sh;
  logic        j_long;
  logic [63:0] j_total;
  logic [63:0] j_hl;
  logic [31:0] room;
  logic        j_short;
  logic        j_over;
  logic        j_match;
  logic [63:0] j_skip;
  logic        j_tail_fit;
  logic        do_judge;
  logic        found;
  outcome_t    found_code;

  assign first = (cur.byte_pos == '0);
  assign bs    = first ? cfg.range_start : cur.box_start;
  assign hc0   = first ? '0 : cur.hdr_cnt;
  assign skip0 = first ? '0 : cur.skip_rem;
  assign done0 = first ? 1'b0 : cur.scan_done;
  assign hc1   = hc0 + 5'd1;
  assign skip_dec = skip0 - 64'd1;

  assign fit8  = ({1'b0, bs} + 33'd8)  <= {1'b0, cfg.range_end};
  assign fit16 = ({1'b0, bs} + 33'd16) <= {1'b0, cfg.range_end};
  assign fit24 = ({1'b0, bs} + 33'd24) <= {1'b0, cfg.range_end};

  assign sw_sh = {cur.size_word[23:0], data_byte};
  assign tw_sh = {cur.type_word[23:0], data_byte};
  assign ls_sh = {cur.large_size[55:0], data_byte};

  // Judge a complete header. On the short path the type word is the one just
  // finished; on the long path it was finished eight bytes earlier.
  assign j_long  = (hc1 == HDR_LONG);
  assign j_total = j_long ? ls_sh : {32'd0, cur.size_word};
  assign j_hl    = j_long ? {59'd0, HDR_LONG} : {59'd0, HDR_SHORT};
  assign room    = cfg.range_end - bs;   // header fits, so no wrap
  assign j_short = j_total < j_hl;
  assign j_over  = j_total > {32'd0, room};
  assign j_match = (j_long ? cur.type_word : tw_sh) == cfg.target_type;
  assign j_skip  = j_total - j_hl;
  // Empty payload: the next header starts right after this one.
  assign j_tail_fit = j_long ? fit24 : fit16;

  always_comb begin
    nxt = cur;
    nxt.box_start = bs;
    nxt.hdr_cnt   = hc0;
    nxt.skip_rem  = skip0;
    nxt.scan_done = done0;
    nxt.byte_pos  = (cur.byte_pos == '1) ? cur.byte_pos : cur.byte_pos + 32'd1;
    emit       = 1'b0;
    found      = 1'b0;
    found_code = OUTC_IN_RANGE;
    do_judge   = 1'b0;

    if (!done0) begin
      if (skip0 != '0) begin
        nxt.skip_rem = skip_dec;
        if (skip_dec == '0 && !fit8) begin
          emit = 1'b1;
        end
      end else if (hc0 == '0 && !fit8) begin
        emit = 1'b1;
      end else begin
        if (hc0 < 5'd4) begin
          nxt.size_word = sw_sh;
        end else if (hc0 < HDR_SHORT) begin
          nxt.type_word = tw_sh;
        end else begin
          nxt.large_size = ls_sh;
        end
        nxt.hdr_cnt = hc1;
        if (hc1 == HDR_SHORT) begin
          if (cur.size_word == 32'd1) begin
            if (!fit16) begin
              emit = 1'b1;
            end
          end else if (cur.size_word == 32'd0) begin
            emit = 1'b1;
          end else begin
            do_judge = 1'b1;
          end
        end else if (j_long) begin
          do_judge = 1'b1;
        end
      end

      if (do_judge) begin
        if (j_short) begin
          emit = 1'b1;
        end else if (j_over) begin
          emit = 1'b1;
          if (j_match && cfg.allow_beyond) begin
            found      = 1'b1;
            found_code = OUTC_BEYOND;
          end
        end else if (j_match) begin
          emit  = 1'b1;
          found = 1'b1;
        end else begin
          nxt.skip_rem  = j_skip;
          nxt.box_start = bs + j_total[31:0];
          nxt.hdr_cnt   = '0;
          if (j_skip == '0 && !j_tail_fit) begin
            emit = 1'b1;
          end
        end
      end
    end

    if (emit) begin
      nxt.scan_done = 1'b1;
    end

    if (last_byte) begin
      if (!nxt.scan_done) begin
        emit = 1'b1;
      end
      nxt.byte_pos  = '0;
      nxt.box_start = '0;
      nxt.hdr_cnt   = '0;
      nxt.skip_rem  = '0;
      nxt.scan_done = 1'b0;
    end

    if (found) begin
      res.outcome        = found_code;
      res.header_offset  = bs;
      res.payload_offset = bs + j_hl[31:0];
      res.payload_size   = j_skip;
      res.total_size     = j_total;
    end else begin
      res.outcome        = OUTC_NONE;
      res.header_offset  = '0;
      res.payload_offset = '0;
      res.payload_size   = '0;
      res.total_size     = '0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/box_header_scanner_unit.sv @@
`default_nettype none
// Box header scanner: takes one buffer byte per clock (in_valid/in_stall) and
// walks sibling ISO base media box headers from range_start, skipping payloads
// until a box of target_type turns up. Each byte is settled in the same cycle
// it is accepted, so a byte request is taken every clock while the result side
// keeps up; the scan state registers are the only loop. At most one result
// request per scan leaves on out_*: it is written on the byte that decides the
// scan (header done, size bad, header or box past range_end), or on the byte
// marked last if nothing decided earlier. A two-deep result buffer (output
// register plus skid register) lets input bytes keep flowing while a result
// waits; in_stall rises only when both hold a result. Outcome 0 means not
// found and then every other result field is zero. Program the cfg registers
// only while the block is idle; the scan restarts after every last byte.
module box_header_scanner_unit import bhs_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  // configuration write port
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_wdata,
  // byte requests
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_last_byte,
  // result requests
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_outcome,
  output logic [31:0] out_header_offset,
  output logic [31:0] out_payload_offset,
  output logic [63:0] out_payload_size,
  output logic [63:0] out_total_size
);

  cfg_t        cfg_r;
  scan_state_t state_r;
  scan_state_t state_nxt;
  logic        step_emit;
  result_t     step_res;
  logic        in_acc;
  logic        out_take;
  logic        out_vld_r;
  logic        skid_vld_r;
  result_t     out_r;
  result_t     skid_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_START:  cfg_r.range_start  <= cfg_wdata;
        CFG_RANGE_END:    cfg_r.range_end    <= cfg_wdata;
        CFG_TARGET_TYPE:  cfg_r.target_type  <= cfg_wdata;
        CFG_ALLOW_BEYOND: cfg_r.allow_beyond <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  bhs_step u_step (
    .cur       (state_r),
    .cfg       (cfg_r),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .nxt       (state_nxt),
    .emit      (step_emit),
    .res       (step_res)
  );

  assign in_stall = skid_vld_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_vld_r && !out_stall;

  // Scan state advances once per accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // Result buffer: output register, then skid when the output is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (in_acc && step_emit) begin
        if (!out_vld_r || out_take) begin
          out_vld_r <= 1'b1;
        end else begin
          skid_vld_r <= 1'b1;
        end
      end else if (out_take) begin
        out_vld_r  <= skid_vld_r;
        skid_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && step_emit) begin
      if (!out_vld_r || out_take) begin
        out_r <= step_res;
      end else begin
        skid_r <= step_res;
      end
    end else if (out_take && skid_vld_r) begin
      out_r <= skid_r;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_outcome        = out_r.outcome;
  assign out_header_offset  = out_r.header_offset;
  assign out_payload_offset = out_r.payload_offset;
  assign out_payload_size   = out_r.payload_size;
  assign out_total_size     = out_r.total_size;

`include "box_header_scanner_unit_assert.svh"

  // skid only fills behind a held output
  `BHS_ASSERT(a_skid_behind_out, skid_vld_r |-> out_vld_r)
  // a found box has an 8- or 16-byte header
  `BHS_ASSERT(a_found_hdr_len, (out_vld_r && out_r.outcome != OUTC_NONE) |-> ((out_r.payload_offset - out_r.header_offset) == 32'd8 || (out_r.payload_offset - out_r.header_offset) == 32'd16))
  // not found carries a zero total size and a zero header offset
  `BHS_ASSERT(a_none_zero, (out_vld_r && out_r.outcome == OUTC_NONE) |-> (out_r.total_size == '0 && out_r.header_offset == '0))
  // the last byte always restarts the scan
  `BHS_ASSERT(a_last_restarts, (in_acc && in_last_byte) |=> (state_r.byte_pos == '0 && !state_r.scan_done))
  // reset leaves no result pending
  `BHS_ASSERT_RST(a_reset_empty, !rst_n |=> (!out_vld_r && !skid_vld_r))

endmodule
`default_nettype wire

@@ tb/sv/tb_box_header_scanner_unit.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the box header scanner. Byte requests go in through
// a queue-fed driver, result requests are compared by a monitor against a
// scan predictor that runs on every accepted byte.
module tb_box_header_scanner_unit;
  import bhs_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int ITEM_TARGET = 1600;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  // ---------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_RANGE_START;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_outcome;
  logic [31:0] out_header_offset;
  logic [31:0] out_payload_offset;
  logic [63:0] out_payload_size;
  logic [63:0] out_total_size;

  box_header_scanner_unit i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Bench bookkeeping
  // ---------------------------------------------------------------------------
  byte_req_t   feed_q[$];        // byte requests not yet presented
  result_t     answers_q[$];     // predicted results, oldest first
  int unsigned bytes_sent = 0;   // bytes put into feed_q
  int unsigned bytes_taken = 0;  // bytes accepted by the DUT
  int unsigned mismatch_count = 0;
  int unsigned cycles = 0;
  int          send_idle_pct = 38;
  int          recv_idle_pct = 61;

  // Bench copy of the registers (reset values) and of the scan state.
  logic [31:0] rs_cfg = '0;
  logic [31:0] re_cfg = '0;
  logic [31:0] tgt_cfg = '0;
  logic        allow_cfg = 1'b0;

  logic [31:0] pos_st = '0;
  logic [31:0] box_st = '0;
  logic [4:0]  hdr_st = '0;
  logic [31:0] size_st = '0;
  logic [31:0] type_st = '0;
  logic [63:0] large_st = '0;
  logic [63:0] skip_st = '0;
  logic        done_st = 1'b0;

  // ---------------------------------------------------------------------------
  // Scan predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_scan();
    pos_st   = '0;
    box_st   = '0;
    hdr_st   = '0;
    size_st  = '0;
    type_st  = '0;
    large_st = '0;
    skip_st  = '0;
    done_st  = 1'b0;
  endfunction

  // Does a header of len bytes at box_st end at or before range_end? No wrap.
  function automatic logic room_for(input logic [4:0] len);
    return ({1'b0, box_st} + 33'(len)) <= {1'b0, re_cfg};
  endfunction

  // Fill in the answer for the box at box_st and close the scan.
  function automatic void settle(output result_t r, input outcome_t oc,
                                 input logic [4:0] hl, input logic [63:0] tot);
    r = '0;
    if (oc != OUTC_NONE) begin
      r.outcome        = oc;
      r.header_offset  = box_st;
      r.payload_offset = box_st + 32'(hl);
      r.payload_size   = tot - 64'(hl);
      r.total_size     = tot;
    end
    done_st = 1'b1;
  endfunction

  // Header complete: report, or set up the payload skip toward the next sibling.
  function automatic logic close_header(output result_t r, input logic [63:0] tot,
                                        input logic [4:0] hl);
    logic [63:0] room;
    logic        hit;
    r    = '0;
    room = {32'b0, re_cfg} - {32'b0, box_st};
    hit  = (type_st == tgt_cfg);
    if (tot < 64'(hl)) begin
      settle(r, OUTC_NONE, 5'd0, 64'd0);
      return 1'b1;
    end
    if (tot > room) begin
      // runs past range_end: only a matching box may be reported, and only if allowed
      if (hit && allow_cfg) settle(r, OUTC_BEYOND, hl, tot);
      else settle(r, OUTC_NONE, 5'd0, 64'd0);
      return 1'b1;
    end
    if (hit) begin
      settle(r, OUTC_IN_RANGE, hl, tot);
      return 1'b1;
    end
    skip_st = tot - 64'(hl);
    box_st  = box_st + tot[31:0];
    hdr_st  = '0;
    // empty payload: next header must fit right away
    if (skip_st == 64'd0 && !room_for(HDR_SHORT)) begin
      settle(r, OUTC_NONE, 5'd0, 64'd0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // One accepted byte; returns 1 when it produces a result request.
  function automatic logic walk_byte(input logic [7:0] b, input logic last,
                                     output result_t r);
    logic       got;
    logic [5:0] hc;
    got = 1'b0;
    r   = '0;
    if (pos_st == '0) begin
      box_st  = rs_cfg;
      hdr_st  = '0;
      skip_st = '0;
      done_st = 1'b0;
    end
    if (pos_st != '1) pos_st++;
    if (!done_st) begin
      if (skip_st != 64'd0) begin
        skip_st--;
        if (skip_st == 64'd0 && !room_for(HDR_SHORT)) begin
          settle(r, OUTC_NONE, 5'd0, 64'd0);
          got = 1'b1;
        end
      end else if (hdr_st == '0 && !room_for(HDR_SHORT)) begin
        settle(r, OUTC_NONE, 5'd0, 64'd0);
        got = 1'b1;
      end else begin
        hc = {1'b0, hdr_st};
        if (hc < 6'd4) size_st = {size_st[23:0], b};
        else if (hc < 6'd8) type_st = {type_st[23:0], b};
        else large_st = {large_st[55:0], b};
        hc++;
        hdr_st = hc[4:0];
        if (hc == 6'(HDR_SHORT)) begin
          if (size_st == 32'd1) begin
            // large size follows; the long header has to fit
            if (!room_for(HDR_LONG)) begin
              settle(r, OUTC_NONE, 5'd0, 64'd0);
              got = 1'b1;
            end
          end else if (size_st == 32'd0) begin
            settle(r, OUTC_NONE, 5'd0, 64'd0);
            got = 1'b1;
          end else begin
            got = close_header(r, {32'b0, size_st}, HDR_SHORT);
          end
        end else if (hc >= 6'(HDR_LONG)) begin
          got = close_header(r, large_st, HDR_LONG);
        end
      end
    end
    if (last) begin
      // nothing decided by the final byte: not found
      if (!done_st) begin
        settle(r, OUTC_NONE, 5'd0, 64'd0);
        got = 1'b1;
      end
      clear_scan();
    end
    return got;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("ERROR t=%0t %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued byte requests, holds them while stalled, and runs
  // the predictor on every accepted byte.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    result_t   res;
    byte_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (walk_byte(in_data_byte, in_last_byte, res))
          answers_q.insert(answers_q.size(), res);
        bytes_taken++;
      end
      // a stalled request stays put; otherwise pick the next one or idle
      if (!in_valid || !in_stall) begin
        if (feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = feed_q.pop_front();
          in_valid     <= 1'b1;
          in_data_byte <= nxt.data;
          in_last_byte <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random result stall, field-by-field compare on every handshake
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_q.size() == 0) begin
          flag_mismatch("result with none pending", 64'(out_outcome), 64'd0);
        end else begin
          want = answers_q.pop_front();
          if (out_outcome !== want.outcome)
            flag_mismatch("outcome", 64'(out_outcome), 64'(want.outcome));
          if (out_header_offset !== want.header_offset)
            flag_mismatch("header_offset", 64'(out_header_offset), 64'(want.header_offset));
          if (out_payload_offset !== want.payload_offset)
            flag_mismatch("payload_offset", 64'(out_payload_offset),
                          64'(want.payload_offset));
          if (out_payload_size !== want.payload_size)
            flag_mismatch("payload_size", out_payload_size, want.payload_size);
          if (out_total_size !== want.total_size)
            flag_mismatch("total_size", out_total_size, want.total_size);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_req(input logic [7:0] data, input logic last);
    byte_req_t req;
    req.data = data;
    req.last = last;
    feed_q.insert(feed_q.size(), req);
    bytes_sent++;
  endtask

  // big-endian word; last marks its final byte when asked
  task automatic push_word(input logic [31:0] w, input logic last);
    for (int i = 3; i >= 0; i--) push_req(w[8*i +: 8], last && i == 0);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RANGE_START:  rs_cfg = val;
      CFG_RANGE_END:    re_cfg = val;
      CFG_TARGET_TYPE:  tgt_cfg = val;
      CFG_ALLOW_BEYOND: allow_cfg = val[0];
      default: ;
    endcase
  endtask

  // Sender holds off until every byte is in and every result is out, then a
  // few spare cycles since trailing ignored bytes never produce a result.
  task automatic drain();
    while (bytes_taken != bytes_sent || answers_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // New scan window and target: edge offsets, empty and inverted ranges,
  // top-of-space windows, the whole address space.
  task automatic pick_window();
    logic [31:0] rs, re, span, tgt;
    case ($urandom_range(0, 5))
      0:       rs = '0;
      1:       rs = 32'hFFFF_FFFF - $urandom_range(0, 300);
      default: rs = $urandom();
    endcase
    case ($urandom_range(0, 7))
      0: re = 32'hFFFF_FFFF;
      1: re = rs - $urandom_range(1, 20);
      2: re = rs;
      default: begin
        span = $urandom_range(0, 160);
        re = (rs > 32'hFFFF_FFFF - span) ? 32'hFFFF_FFFF : rs + span;
      end
    endcase
    case ($urandom_range(0, 3))
      0:       tgt = '0;
      1:       tgt = 32'hFFFF_FFFF;
      default: tgt = $urandom();
    endcase
    write_reg(CFG_RANGE_START, rs);
    write_reg(CFG_RANGE_END, re);
    write_reg(CFG_TARGET_TYPE, tgt);
    write_reg(CFG_ALLOW_BEYOND, 32'($urandom_range(0, 1)));
  endtask

  // One buffer of sibling boxes. Mostly well-formed short boxes with random
  // payload; some large-size headers, zero and undersized sizes, huge boxes.
  // Payload after a decisive box is kept short since the scan ignores it.
  task automatic queue_scan();
    logic [7:0]  raw[$];
    logic [31:0] size32, box_type;
    logic [63:0] tot, body;
    int          kind, nbox, keep, hl;
    logic        stop;
    nbox = $urandom_range(1, 5);
    stop = 1'b0;
    for (int k = 0; k < nbox && !stop; k++) begin
      box_type = ($urandom_range(0, 3) == 0) ? tgt_cfg : $urandom();
      kind = $urandom_range(0, 19);
      tot = '0;
      case (kind)
        12, 13:  begin size32 = 32'd1; tot = 64'd16 + $urandom_range(0, 24); end
        14:      begin size32 = 32'd1; tot = {$urandom(), $urandom()}; end
        15:      begin size32 = 32'd1; tot = 64'($urandom_range(0, 15)); end
        16:      size32 = 32'd0;
        17:      size32 = $urandom_range(2, 7);
        18:      size32 = $urandom() | 32'h8000_0000;
        19:      size32 = $urandom();
        default: size32 = 32'd8 + $urandom_range(0, 24);
      endcase
      if (size32 != 32'd1) tot = {32'b0, size32};
      for (int i = 3; i >= 0; i--) raw.insert(raw.size(), size32[8*i +: 8]);
      for (int i = 3; i >= 0; i--) raw.insert(raw.size(), box_type[8*i +: 8]);
      if (size32 == 32'd1)
        for (int i = 7; i >= 0; i--) raw.insert(raw.size(), tot[8*i +: 8]);
      hl = (size32 == 32'd1) ? 16 : 8;
      if (size32 == 32'd0 || tot < 64'(hl)) begin
        stop = 1'b1;
      end else begin
        body = tot - 64'(hl);
        if (body > 64'd40 || box_type == tgt_cfg) begin
          body = 64'($urandom_range(0, 4));
          stop = 1'b1;
        end
        repeat (body) raw.insert(raw.size(), 8'($urandom_range(0, 255)));
      end
    end
    // now and then the buffer ends early, or carries some trailing noise
    keep = raw.size();
    if ($urandom_range(0, 5) == 0) begin
      keep = $urandom_range(1, raw.size());
    end else if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4)) raw.insert(raw.size(), 8'($urandom_range(0, 255)));
      keep = raw.size();
    end
    for (int i = 0; i < keep; i++) push_req(raw[i], i == keep - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Run watchdog
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL box_header_scanner_unit");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed. Reset window is empty (start 0, end 0): header cannot fit,
    // answer on the first byte.
    push_req(8'h00, 1'b1);
    drain();

    // Whole space from offset 100, all-ones target.
    write_reg(CFG_RANGE_START, 32'd100);
    write_reg(CFG_RANGE_END, 32'hFFFF_FFFF);
    write_reg(CFG_TARGET_TYPE, 32'hFFFF_FFFF);
    write_reg(CFG_ALLOW_BEYOND, 32'd0);
    // header-only box of the target type: found in range
    push_word(32'd8, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1);
    // size zero: not found on the header's last byte, which is also the last
    push_word(32'd0, 1'b0);
    push_word(32'hAA55_1234, 1'b1);
    drain();

    // 15 bytes of room: a large-size header is truncated
    write_reg(CFG_RANGE_START, 32'hFFFF_FFF0);
    push_word(32'd1, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1);
    drain();

    // Random phases: new window each phase, drained before the next writes.
    // Pacing: receiver-heavy idling, then sender-heavy, then none.
    while (bytes_sent < ITEM_TARGET) begin
      if (bytes_sent < ITEM_TARGET / 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 61;
      end else if (bytes_sent < 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick_window();
      repeat ($urandom_range(3, 8)) begin
        if (bytes_sent < ITEM_TARGET) queue_scan();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (answers_q.size() != 0)
      flag_mismatch("results never seen", 64'(answers_q.size()), 64'd0);
    if (mismatch_count == 0) begin
      $display("PASS box_header_scanner_unit");
    end else begin
      $display("FAIL box_header_scanner_unit");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bhs_pkg.sv
rtl/bhs_step.sv
rtl/box_header_scanner_unit.sv
tb/sv/tb_box_header_scanner_unit.sv
